@@ hdl/csol_pkg.sv @@
// ----------------------------------------------------------------------------
// csol_pkg
// Shared types and constants for the column span occlusion list.
// ----------------------------------------------------------------------------
`default_nettype none

package csol_pkg;

   localparam int COL_W  = 12;   // screen column
   localparam int POS_W  = 14;   // stored post bound, signed
   localparam int SW_W   = 13;   // screen width register
   localparam int EMIT_W = 5;    // results per request counter
   localparam int ADDR_W = 3;

   localparam int DEFAULT_MAX_RANGES = 32;
   localparam int RESULT_CAP         = 31;

   localparam logic [SW_W-1:0] SW_RESET = 13'd320;

   // infinities of the edge posts
   localparam logic signed [POS_W-1:0] POS_NEG_INF = 14'sh2000;
   localparam logic signed [POS_W-1:0] POS_INF     = 14'sh1fff;
   localparam logic signed [POS_W-1:0] EDGE_END    = 14'sh3fff;   // -1

   localparam logic REG_SCREEN_WIDTH = 1'b0;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_SOLID = 2'd1,
      REQ_PASS  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEEK,
      ST_HEAD,
      ST_CHECK,
      ST_COPY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [POS_W-1:0] lo;
      logic signed [POS_W-1:0] hi;
   } post_type;

   typedef struct packed {
      logic clr;
      logic pop;
      logic push;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ hdl/csol_cell.sv @@
// ----------------------------------------------------------------------------
// csol_cell
// One post of the occlusion list; shifts toward the head on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module csol_cell #(
   parameter int MAX_RANGES = csol_pkg::DEFAULT_MAX_RANGES,
   parameter int IDX        = 0
) (
   input  wire                              clock,
   input  csol_pkg::cell_ctl_type           ctl,
   input  wire [$clog2(MAX_RANGES)-1:0]     wr_idx,
   input  csol_pkg::post_type               clr_post,
   input  csol_pkg::post_type               push_post,
   input  csol_pkg::post_type               next_post,
   output csol_pkg::post_type               cell_post
);
   import csol_pkg::*;

   localparam int IDX_W = $clog2(MAX_RANGES);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   post_type post_ff;
   post_type post_in;

   always_comb begin
      post_in = post_ff;
      if (ctl.clr) begin
         post_in = clr_post;
      end else if (ctl.push && (wr_idx == MY_IDX)) begin
         post_in = push_post;
      end else if (ctl.pop) begin
         post_in = next_post;
      end
   end

   always_ff @(posedge clock) begin
      post_ff <= post_in;
   end

   assign cell_post = post_ff;

endmodule

`default_nettype wire

@@ hdl/column_span_occlusion_list.sv @@
// ----------------------------------------------------------------------------
// column_span_occlusion_list
// Clips column ranges against a sorted list of occluded spans.
// ----------------------------------------------------------------------------
// The list lives in a row of cells that shift toward the head. A solid or
// pass request walks the whole list once, one post per cycle while the
// result side does not stall, writing each post (merged or copied) back at
// the tail. The final result is sent after the walk, and the next request
// is taken only once it has been sent. Fragments leave in column order, one
// per cycle at most; last_of_run marks the final result. Clear and empty
// requests give one empty result. screen_width takes effect at the next
// clear.
`default_nettype none

module column_span_occlusion_list #(
   parameter int MAX_RANGES = csol_pkg::DEFAULT_MAX_RANGES
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire [1:0]                        req_type,
   input  wire [csol_pkg::COL_W-1:0]        req_range_first,
   input  wire [csol_pkg::COL_W-1:0]        req_range_last,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_frag_valid,
   output logic [csol_pkg::COL_W-1:0]       rsp_frag_first,
   output logic [csol_pkg::COL_W-1:0]       rsp_frag_last,
   output logic                             rsp_overflow,
   output logic                             rsp_last_of_run,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire [csol_pkg::ADDR_W-1:0]       paddr,
   input  wire [31:0]                       pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import csol_pkg::*;

   localparam int IDX_W = $clog2(MAX_RANGES);
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RANGES);
   localparam logic [EMIT_W-1:0] EMIT_CAP = EMIT_W'(RESULT_CAP);

   // configuration
   logic [SW_W-1:0] sw_ff;
   logic            csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_SCREEN_WIDTH);
   assign prdata = (paddr[2] == REG_SCREEN_WIDTH) ? {{(32-SW_W){1'b0}}, sw_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= SW_RESET;
      end else if (csr_wr) begin
         sw_ff <= pwdata[SW_W-1:0];
      end
   end

   // sequencer state
   state_type        state_ff, state_in;
   logic             solid_ff, solid_in;
   logic [COL_W-1:0] first_ff, first_in;
   logic [COL_W-1:0] last_ff, last_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic signed [POS_W-1:0] ms_ff, ms_in;
   logic [EMIT_W-1:0] emit_cnt_ff, emit_cnt_in;

   // one fragment held back until we know whether it is the last
   logic             pend_v_ff, pend_v_in;
   logic [COL_W-1:0] pend_first_ff, pend_first_in;
   logic [COL_W-1:0] pend_last_ff, pend_last_in;
   logic             pend_ovf_ff, pend_ovf_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_fv_ff, rsp_fv_in;
   logic [COL_W-1:0] rsp_first_ff, rsp_first_in;
   logic [COL_W-1:0] rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;
   logic             rsp_lor_ff, rsp_lor_in;

   // cell row
   post_type         chain [MAX_RANGES];
   post_type         head, nxt;
   post_type         push_post;
   post_type         clr_l, clr_r;
   cell_ctl_type     ctl;
   logic [IDX_W-1:0] wr_idx;

   assign head = chain[0];
   assign nxt  = chain[1];

   assign clr_l.lo = POS_NEG_INF;
   assign clr_l.hi = EDGE_END;
   assign clr_r.lo = $signed({1'b0, (reset ? SW_RESET : sw_ff)});
   assign clr_r.hi = POS_INF;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_RANGES; gi++) begin : g_cell
         post_type nb;
         if (gi == MAX_RANGES - 1) begin : g_tail
            assign nb = chain[gi];
         end else begin : g_body
            assign nb = chain[gi+1];
         end
         csol_cell #(
            .MAX_RANGES (MAX_RANGES),
            .IDX        (gi)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .wr_idx    (wr_idx),
            .clr_post  ((gi == 0) ? clr_l : clr_r),
            .push_post (push_post),
            .next_post (nb),
            .cell_post (chain[gi])
         );
      end
   endgenerate

   // datapath helpers
   logic signed [POS_W-1:0] f_s, l_s, fm1, lp1;
   logic             out_free, can_emit, emit_keep, go;
   logic             emit_req, emit_ovf;
   logic [COL_W-1:0] emit_first, emit_last;
   logic             accept, full;
   logic             pop_w, push_w;
   state_type        step_state;
   logic signed [POS_W-1:0] step_ms;

   assign f_s = $signed({2'b00, first_ff});
   assign l_s = $signed({2'b00, last_ff});
   assign fm1 = f_s - 14'sd1;
   assign lp1 = l_s + 14'sd1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign can_emit  = !pend_v_ff || out_free;
   assign emit_keep = emit_cnt_ff < EMIT_CAP;
   assign full      = (occ_ff == CNT_FULL);
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // one step of the list walk, before output back pressure
   always_comb begin
      step_state = state_ff;
      step_ms    = ms_ff;
      pop_w      = 1'b0;
      push_w     = 1'b0;
      push_post  = head;
      emit_req   = 1'b0;
      emit_ovf   = 1'b0;
      emit_first = '0;
      emit_last  = '0;
      case (state_ff)
         ST_SEEK: begin
            if ((rem_ff > CNT_ONE) && (head.hi < fm1)) begin
               pop_w  = 1'b1;
               push_w = 1'b1;
            end else begin
               step_state = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (f_s < head.lo) begin
               if (lp1 < head.lo) begin
                  // range sits wholly in the gap before this post
                  emit_req   = 1'b1;
                  emit_first = first_ff;
                  emit_last  = last_ff;
                  emit_ovf   = solid_ff && full;
                  push_w     = solid_ff && !full;
                  push_post  = '{lo: f_s, hi: l_s};
                  step_state = ST_COPY;
               end else begin
                  emit_req   = 1'b1;
                  emit_first = first_ff;
                  emit_last  = head.lo[COL_W-1:0] - COL_W'(1);
                  step_ms    = solid_ff ? f_s : head.lo;
                  step_state = ST_CHECK;
               end
            end else begin
               step_ms    = head.lo;
               step_state = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (l_s <= head.hi) begin
               pop_w      = 1'b1;
               push_w     = 1'b1;
               push_post  = solid_ff ? '{lo: ms_ff, hi: head.hi} : head;
               step_state = ST_COPY;
            end else if ((rem_ff > CNT_ONE) && (lp1 >= nxt.lo)) begin
               // bridge the gap to the next post
               emit_req   = 1'b1;
               emit_first = head.hi[COL_W-1:0] + COL_W'(1);
               emit_last  = nxt.lo[COL_W-1:0] - COL_W'(1);
               pop_w      = 1'b1;
               push_w     = !solid_ff;
            end else begin
               emit_req   = 1'b1;
               emit_first = head.hi[COL_W-1:0] + COL_W'(1);
               emit_last  = last_ff;
               pop_w      = 1'b1;
               push_w     = 1'b1;
               push_post  = solid_ff ? '{lo: ms_ff, hi: l_s} : head;
               step_state = ST_COPY;
            end
         end
         ST_COPY: begin
            if (rem_ff == '0) begin
               step_state = ST_FINISH;
            end else begin
               pop_w  = 1'b1;
               push_w = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign go = !(emit_req && emit_keep) || can_emit;

   always_comb begin
      state_in      = state_ff;
      solid_in      = solid_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      rem_in        = rem_ff;
      occ_in        = occ_ff;
      ms_in         = ms_ff;
      emit_cnt_in   = emit_cnt_ff;
      pend_v_in     = pend_v_ff;
      pend_first_in = pend_first_ff;
      pend_last_in  = pend_last_ff;
      pend_ovf_in   = pend_ovf_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_fv_in     = rsp_fv_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_lor_in    = rsp_lor_ff;
      ctl           = '{clr: reset, pop: 1'b0, push: 1'b0};
      wr_idx        = occ_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               solid_in    = (req_kind_type'(req_type) == REQ_SOLID);
               first_in    = req_range_first;
               last_in     = req_range_last;
               rem_in      = occ_ff;
               emit_cnt_in = '0;
               pend_v_in   = 1'b0;
               state_in    = ST_FINISH;
               case (req_kind_type'(req_type))
                  REQ_CLEAR: begin
                     ctl.clr = 1'b1;
                     occ_in  = CNT_TWO;
                  end
                  REQ_SOLID, REQ_PASS: begin
                     if (req_range_first <= req_range_last) begin
                        state_in = ST_SEEK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_fv_in    = pend_v_ff;
               rsp_first_in = pend_v_ff ? pend_first_ff : '0;
               rsp_last_in  = pend_v_ff ? pend_last_ff : '0;
               rsp_ovf_in   = pend_v_ff && pend_ovf_ff;
               rsp_lor_in   = 1'b1;
               pend_v_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            if (go) begin
               state_in = step_state;
               ms_in    = step_ms;
               ctl.pop  = pop_w;
               ctl.push = push_w;
               wr_idx   = pop_w ? (occ_ff[IDX_W-1:0] - IDX_W'(1)) : occ_ff[IDX_W-1:0];
               occ_in   = occ_ff - CNT_W'(pop_w) + CNT_W'(push_w);
               rem_in   = rem_ff - CNT_W'(pop_w);
               if (emit_req && emit_keep) begin
                  if (pend_v_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_fv_in    = 1'b1;
                     rsp_first_in = pend_first_ff;
                     rsp_last_in  = pend_last_ff;
                     rsp_ovf_in   = pend_ovf_ff;
                     rsp_lor_in   = 1'b0;
                  end
                  pend_v_in     = 1'b1;
                  pend_first_in = emit_first;
                  pend_last_in  = emit_last;
                  pend_ovf_in   = emit_ovf;
                  emit_cnt_in   = emit_cnt_ff + EMIT_W'(1);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= CNT_TWO;
         rem_ff       <= '0;
         emit_cnt_ff  <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rem_ff       <= rem_in;
         emit_cnt_ff  <= emit_cnt_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      solid_ff      <= solid_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      ms_ff         <= ms_in;
      pend_first_ff <= pend_first_in;
      pend_last_ff  <= pend_last_in;
      pend_ovf_ff   <= pend_ovf_in;
      rsp_fv_ff     <= rsp_fv_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_lor_ff    <= rsp_lor_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frag_valid  = rsp_fv_ff;
   assign rsp_frag_first  = rsp_first_ff;
   assign rsp_frag_last   = rsp_last_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_last_of_run = rsp_lor_ff;

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_FULL)
      else $error("list occupancy above capacity");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_v_ff)
      else $error("fragment left pending after request end");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      accept && (req_type == REQ_CLEAR) |=> occ_ff == CNT_TWO)
      else $error("clear did not restore edge posts");

   a_walk_balance: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEEK |-> occ_ff >= rem_ff)
      else $error("remaining posts exceed occupancy");
`endif

endmodule

`default_nettype wire
